### hdl/rsapa_pkg.sv
package rsapa_pkg;

    // block configuration
    localparam int NUM_PORTS    = 8;
    localparam int NUM_STATIONS = 4;
    // the allowed mask and the station map cover at most eight ports
    localparam int SCAN_PORTS   = (NUM_PORTS < 8) ? NUM_PORTS : 8;

    // field widths
    localparam int MASK_W  = 8;
    localparam int PORT_W  = 3;
    localparam int FREE_W  = 32;
    localparam int MAP_W   = 16;
    localparam int CAP_W   = 64;
    localparam int OCC_W   = 8;
    localparam int COUNT_W = 16;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // item modes
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY_MASK = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_IDLE_PORT  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_STATION_MAP      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_STATION_CAPACITY = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic exec;
    } t_cmd;

endpackage

### hdl/rsapa_ctrl.sv
module rsapa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rsapa_pkg::t_cmd o_cmd
);

    rsapa_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    // output slot can take a result this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // command decode
    always_comb begin
        o_cmd.load_in = (r_state == rsapa_pkg::ST_IDLE) && i_in_valid;
        o_cmd.exec    = (r_state == rsapa_pkg::ST_EXEC) && out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsapa_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = rsapa_pkg::ST_EXEC;
            end
            rsapa_pkg::ST_EXEC: begin
                if (out_free) n_state = rsapa_pkg::ST_IDLE;
            end
            default: n_state = rsapa_pkg::ST_IDLE;
        endcase
    end

    // output valid tracking
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsapa_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != rsapa_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hdl/rsapa_dp.sv
module rsapa_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rsapa_pkg::t_cmd                       i_cmd,
    input  logic                                  i_cfg_we,
    input  logic [rsapa_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rsapa_pkg::CAP_W-1:0]           i_cfg_data,
    input  logic                                  i_mode,
    input  logic [rsapa_pkg::MASK_W-1:0]          i_allowed_ports,
    input  logic [rsapa_pkg::PORT_W-1:0]          i_release_port,
    input  logic [rsapa_pkg::FREE_W-1:0]          i_station_free_packed,
    output logic [rsapa_pkg::PORT_W-1:0]          o_chosen_port,
    output logic [rsapa_pkg::STAT_W-1:0]          o_status
);

    // configuration registers
    logic [rsapa_pkg::MAP_W-1:0] r_map;
    logic [rsapa_pkg::CAP_W-1:0] r_cap;

    // captured transaction
    logic                              r_mode;
    logic [rsapa_pkg::MASK_W-1:0]      r_allowed;
    logic [rsapa_pkg::PORT_W-1:0]      r_rport;
    logic [rsapa_pkg::FREE_W-1:0]      r_free;

    // per-port in-flight counters
    logic [rsapa_pkg::COUNT_W-1:0] r_inflight [rsapa_pkg::NUM_PORTS];
    logic [rsapa_pkg::COUNT_W-1:0] n_inflight [rsapa_pkg::NUM_PORTS];

    // result registers
    logic [rsapa_pkg::PORT_W-1:0] r_chosen, n_chosen;
    logic [rsapa_pkg::STAT_W-1:0] r_status, n_status;

    logic [rsapa_pkg::OCC_W-1:0]   occ [rsapa_pkg::SCAN_PORTS];
    logic                          found;
    logic [rsapa_pkg::OCC_W-1:0]   best_occ;
    logic [rsapa_pkg::COUNT_W-1:0] best_cnt;
    logic [rsapa_pkg::PORT_W-1:0]  best_idx;
    logic [rsapa_pkg::NUM_PORTS-1:0] alloc_sel;
    logic [rsapa_pkg::NUM_PORTS-1:0] rel_sel;
    logic                          rel_ok;

    // free entries of one station, zero for stations that do not exist
    function automatic logic [rsapa_pkg::OCC_W-1:0] station_free(
        input logic [rsapa_pkg::FREE_W-1:0] packed_free,
        input logic [1:0]                   station
    );
        logic [rsapa_pkg::OCC_W-1:0] res;
        res = '0;
        for (int s = 0; s < 4; s++) begin
            if ((int'(station) == s) && (s < rsapa_pkg::NUM_STATIONS)) begin
                res = packed_free[8*s +: 8];
            end
        end
        return res;
    endfunction

    // occupancy of each scanned port, floored at zero
    always_comb begin
        for (int p = 0; p < rsapa_pkg::SCAN_PORTS; p++) begin
            logic [rsapa_pkg::OCC_W-1:0] cap;
            logic [rsapa_pkg::OCC_W-1:0] fr;
            cap = r_cap[8*p +: 8];
            fr  = station_free(r_free, r_map[2*p +: 2]);
            occ[p] = (cap > fr) ? (cap - fr) : '0;
        end
    end

    // lexicographic minimum: occupancy, then in-flight count, then index
    always_comb begin
        found     = 1'b0;
        best_occ  = '0;
        best_cnt  = '0;
        best_idx  = '0;
        alloc_sel = '0;
        for (int p = 0; p < rsapa_pkg::SCAN_PORTS; p++) begin
            if (r_allowed[p]) begin
                if (!found || (occ[p] < best_occ) ||
                    ((occ[p] == best_occ) && (r_inflight[p] < best_cnt))) begin
                    found     = 1'b1;
                    best_occ  = occ[p];
                    best_cnt  = r_inflight[p];
                    best_idx  = rsapa_pkg::PORT_W'(p);
                    alloc_sel = '0;
                    alloc_sel[p] = 1'b1;
                end
            end
        end
    end

    // release decode; absent ports never match
    always_comb begin
        rel_ok = 1'b0;
        for (int p = 0; p < rsapa_pkg::NUM_PORTS; p++) begin
            rel_sel[p] = (int'(r_rport) == p);
            if (rel_sel[p] && (r_inflight[p] != '0)) rel_ok = 1'b1;
        end
    end

    // counter and result update
    always_comb begin
        n_chosen = r_chosen;
        n_status = r_status;
        for (int p = 0; p < rsapa_pkg::NUM_PORTS; p++) begin
            n_inflight[p] = r_inflight[p];
        end
        if (i_cmd.exec) begin
            if (r_mode == rsapa_pkg::MODE_ALLOC) begin
                n_chosen = found ? best_idx : '0;
                n_status = found ? rsapa_pkg::STATUS_OK : rsapa_pkg::STATUS_EMPTY_MASK;
                for (int p = 0; p < rsapa_pkg::NUM_PORTS; p++) begin
                    if (found && alloc_sel[p] && (r_inflight[p] != rsapa_pkg::COUNT_MAX)) begin
                        n_inflight[p] = r_inflight[p] + 1'b1;
                    end
                end
            end else begin
                n_chosen = '0;
                n_status = rel_ok ? rsapa_pkg::STATUS_OK : rsapa_pkg::STATUS_IDLE_PORT;
                for (int p = 0; p < rsapa_pkg::NUM_PORTS; p++) begin
                    if (rel_ok && rel_sel[p]) begin
                        n_inflight[p] = r_inflight[p] - 1'b1;
                    end
                end
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
            r_cap <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == rsapa_pkg::CFG_PORT_STATION_MAP) begin
                r_map <= i_cfg_data[rsapa_pkg::MAP_W-1:0];
            end
            if (i_cfg_idx == rsapa_pkg::CFG_PORT_STATION_CAPACITY) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // in-flight counters
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < rsapa_pkg::NUM_PORTS; p++) begin
            if (!i_rst_n) begin
                r_inflight[p] <= '0;
            end else begin
                r_inflight[p] <= n_inflight[p];
            end
        end
    end

    // transaction capture and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode    <= i_mode;
            r_allowed <= i_allowed_ports;
            r_rport   <= i_release_port;
            r_free    <= i_station_free_packed;
        end
        r_chosen <= n_chosen;
        r_status <= n_status;
    end

    assign o_chosen_port = r_chosen;
    assign o_status      = r_status;

endmodule

### hdl/rs_aware_issue_port_allocator_top.sv
// Least-loaded issue-port allocator. Each transaction either allocates a port
// (the allowed port whose reservation station is least occupied, ties to the
// lower in-flight count, then the lower port index; its counter increments
// and saturates) or releases one in-flight entry of a port. Every transaction
// gives exactly one result with the chosen port and a status (ok, empty mask,
// release of an idle port). A transaction is captured in the idle state,
// then port selection and counter update run in the exec state. The result is
// held in an output register, so the next transaction is taken while it
// waits; selection pauses only while that register is still stalled.
// Configuration writes are taken at any time and must come while idle.
module rs_aware_issue_port_allocator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rsapa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rsapa_pkg::CAP_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [rsapa_pkg::MASK_W-1:0]    i_allowed_ports,
    input  logic [rsapa_pkg::PORT_W-1:0]    i_release_port,
    input  logic [rsapa_pkg::FREE_W-1:0]    i_station_free_packed,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [rsapa_pkg::PORT_W-1:0]    o_chosen_port,
    output logic [rsapa_pkg::STAT_W-1:0]    o_status
);

    rsapa_pkg::t_cmd cmd;

    // handshake sequencing
    rsapa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // selection, counters and configuration
    rsapa_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_mode                (i_mode),
        .i_allowed_ports       (i_allowed_ports),
        .i_release_port        (i_release_port),
        .i_station_free_packed (i_station_free_packed),
        .o_chosen_port         (o_chosen_port),
        .o_status              (o_status)
    );

endmodule
